### rtl/b32e_pkg.sv
// Package for the Base32 stream encoder: word types, the job record passed
// from the front to the back, and the symbol-to-ASCII mapping.
// Depends on nothing; every other file of the encoder imports it.
package b32e_pkg;

  localparam int unsigned JobFifoDepth = 4;

  localparam logic [6:0] PadChar = 7'h3D;
  localparam logic [6:0] UpperA  = 7'h41;
  localparam logic [6:0] Digit2  = 7'h32;
  localparam logic [4:0] NumLetters = 5'd26;

  // Pad characters that follow the flush symbol, by group position of the
  // final byte.
  localparam logic [2:0] PadAfterPos0 = 3'd6;
  localparam logic [2:0] PadAfterPos1 = 3'd4;
  localparam logic [2:0] PadAfterPos2 = 3'd3;
  localparam logic [2:0] PadAfterPos3 = 3'd1;

  localparam logic [2:0] LastPos = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_of_run;
  } out_word_t;

  // One job per input byte: the symbols it completes, plus flush and padding.
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic       has_sym1;
    logic       flush;
    logic [4:0] flush_val;
    logic [2:0] pad_cnt;
  } job_t;

  typedef enum logic [1:0] {
    PH_SYM0,
    PH_SYM1,
    PH_FLUSH,
    PH_PAD
  } phase_e;

  function automatic logic [6:0] sym_char(input logic [4:0] v);
    logic [4:0] d;
    d = v - NumLetters;
    if (v < NumLetters) begin
      return UpperA + {2'b00, v};
    end else begin
      return Digit2 + {2'b00, d};
    end
  endfunction

endpackage

### rtl/b32e_front.sv
// Front end of the Base32 encoder: accepts bytes, tracks the group position
// and leftover bits, and turns each byte into a job record. Uses b32e_pkg.
module b32e_front
  import b32e_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_word_i,
  output job_t     job_o
);

  logic [2:0] pos_q, pos_d;
  logic [3:0] left_q, left_d;
  logic [3:0] left_new;
  logic [2:0] pos_inc;
  logic [2:0] pad_new;
  logic [7:0] b;

  assign b = in_word_i.data_byte;

  always_comb begin
    job_o          = '0;
    left_new       = '0;
    pad_new        = '0;
    pos_inc        = 3'd1;
    case (pos_q)
      3'd1: begin
        job_o.sym0      = {left_q[2:0], b[7:6]};
        job_o.sym1      = b[5:1];
        job_o.has_sym1  = 1'b1;
        left_new        = {3'b000, b[0]};
        job_o.flush_val = {b[0], 4'b0000};
        pad_new         = PadAfterPos1;
        pos_inc         = 3'd2;
      end
      3'd2: begin
        job_o.sym0      = {left_q[0], b[7:4]};
        left_new        = b[3:0];
        job_o.flush_val = {b[3:0], 1'b0};
        pad_new         = PadAfterPos2;
        pos_inc         = 3'd3;
      end
      3'd3: begin
        job_o.sym0      = {left_q[3:0], b[7]};
        job_o.sym1      = b[6:2];
        job_o.has_sym1  = 1'b1;
        left_new        = {2'b00, b[1:0]};
        job_o.flush_val = {b[1:0], 3'b000};
        pad_new         = PadAfterPos3;
        pos_inc         = LastPos;
      end
      LastPos: begin
        job_o.sym0      = {left_q[1:0], b[7:5]};
        job_o.sym1      = b[4:0];
        job_o.has_sym1  = 1'b1;
        pos_inc         = 3'd0;
      end
      default: begin
        // Start of a group; positions that cannot occur are treated alike.
        job_o.sym0      = b[7:3];
        left_new        = {1'b0, b[2:0]};
        job_o.flush_val = {b[2:0], 2'b00};
        pad_new         = PadAfterPos0;
        pos_inc         = 3'd1;
      end
    endcase

    job_o.flush   = in_word_i.final_byte && (pos_q != LastPos);
    job_o.pad_cnt = job_o.flush ? pad_new : 3'd0;

    pos_d  = pos_q;
    left_d = left_q;
    if (push_i) begin
      pos_d  = in_word_i.final_byte ? 3'd0 : pos_inc;
      left_d = in_word_i.final_byte ? 4'd0 : left_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      left_q <= '0;
    end else begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

endmodule

### rtl/b32e_fifo.sv
// Short job queue between the front and the back of the Base32 encoder.
// Register array with a head read; uses job_t from b32e_pkg.
module b32e_fifo
  import b32e_pkg::*;
#(
  parameter int unsigned Depth = JobFifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic rd_en_i,
  output logic rd_valid_o,
  output job_t rd_job_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  job_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic wr_fire, rd_fire;

  assign full_o     = (cnt_q == FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign wr_fire    = wr_en_i && !full_o;
  assign rd_fire    = rd_en_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_fire && !wr_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

### rtl/b32e_back.sv
// Back end of the Base32 encoder (uses b32e_pkg): steps each job into an
// output register, one character per cycle while it is empty or popped.
module b32e_back
  import b32e_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_job_i,
  output logic      head_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  job_t      cur_q, cur_d, job;
  logic      cur_valid_q, cur_valid_d;
  phase_e    phase_q, phase_d, ph, nxt;
  logic [2:0] pad_left_q, pad_left_d, nxt_pad;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      have, advance, done;
  logic [6:0] ch;

  assign job  = cur_valid_q ? cur_q : head_job_i;
  assign ph   = cur_valid_q ? phase_q : PH_SYM0;
  assign have = cur_valid_q || head_valid_i;
  assign advance    = have && (!out_valid_q || pop);
  assign head_pop_o = advance && !cur_valid_q;
  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  // Character for the current phase and the phase that follows it.
  always_comb begin
    ch      = PadChar;
    nxt     = PH_SYM0;
    nxt_pad = pad_left_q;
    done    = 1'b0;
    case (ph)
      PH_SYM0: begin
        ch = sym_char(job.sym0);
        if (job.has_sym1) begin
          nxt = PH_SYM1;
        end else if (job.flush) begin
          nxt = PH_FLUSH;
        end else begin
          done = 1'b1;
        end
      end
      PH_SYM1: begin
        ch = sym_char(job.sym1);
        if (job.flush) begin
          nxt = PH_FLUSH;
        end else begin
          done = 1'b1;
        end
      end
      PH_FLUSH: begin
        ch      = sym_char(job.flush_val);
        nxt     = PH_PAD;
        nxt_pad = job.pad_cnt;
        done    = (job.pad_cnt == 3'd0);
      end
      PH_PAD: begin
        ch      = PadChar;
        nxt     = PH_PAD;
        nxt_pad = pad_left_q - 1'b1;
        done    = (pad_left_q <= 3'd1);
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    pad_left_d  = pad_left_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    if (advance) begin
      out_d.char_code   = ch;
      out_d.last_of_run = done;
      out_valid_d       = 1'b1;
      cur_valid_d       = !done;
      cur_d             = job;
      phase_d           = nxt;
      pad_left_d        = nxt_pad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SYM0;
      pad_left_q  <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      pad_left_q  <= pad_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

endmodule

### rtl/base32_stream_encoder_top.sv
// Top level of the Base32 stream encoder: front, job queue and back.
// Depends on b32e_pkg, b32e_front, b32e_fifo and b32e_back.
//
// Usage: the input side is a queue write port. A byte word (data_byte plus
// final_byte) is taken at a clock edge where push is high and full is low.
// The output side is a queue read port: while empty is low, out_word_o shows
// the oldest character, taken at an edge where pop is high.
// Each byte gives one or two alphabet characters; a final byte adds the
// flush symbol and '=' padding to complete the eight-character group, up to
// eight characters in all. last_of_run marks the last character of a byte.
// The first character of a byte reaches the output ports through the job
// queue and then the output register, where it can be popped.
// Throughput: the front takes a byte every cycle while the job queue has
// room; the back emits one character per cycle while the receiver pops, so
// the sustained rate is set by the character count. When the receiver
// stalls, the output register holds its character, the job queue fills
// and full goes high. Reset clears the group position, the queue and the
// output register.
module base32_stream_encoder_top
  import b32e_pkg::*;
#(
  parameter int unsigned FifoDepth = JobFifoDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word_o
);

  job_t front_job, head_job;
  logic accept, head_valid, head_pop;

  assign accept = push && !full;

  b32e_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .in_word_i (in_word_i),
    .job_o     (front_job)
  );

  b32e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_job_i   (front_job),
    .full_o     (full),
    .rd_en_i    (head_pop),
    .rd_valid_o (head_valid),
    .rd_job_o   (head_job)
  );

  b32e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_pop_o   (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_word_o   (out_word_o)
  );

endmodule

### rtl/b32e_checker.sv
// Port-level checks for the Base32 stream encoder, bound to the top level.
// Depends on b32e_pkg and base32_stream_encoder_top.
module b32e_checker
  import b32e_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  logic out_take;
  logic legal_char;

  assign out_take = pop && !empty;
  assign legal_char =
      ((out_word_o.char_code >= UpperA) && (out_word_o.char_code <= 7'h5A)) ||
      ((out_word_o.char_code >= Digit2) && (out_word_o.char_code <= 7'h37)) ||
      (out_word_o.char_code == PadChar);

  // A waiting word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty |-> legal_char)
    else $error("character outside the Base32 alphabet");

  // The rest of a byte's run follows without a gap.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_take && !out_word_o.last_of_run |=> !empty)
    else $error("gap inside a run of characters");

  // Padding continues with padding until the run ends.
  a_pad_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_take && !out_word_o.last_of_run && (out_word_o.char_code == PadChar)
      |=> out_word_o.char_code == PadChar)
    else $error("non-pad character after padding");

endmodule

bind base32_stream_encoder_top b32e_checker u_b32e_checker (.*);

### test/base32_stream_encoder_top_test.sv
// Testbench for base32_stream_encoder_top: feeds byte messages through the queue-style
// input, predicts the Base32 characters each byte yields, and checks them in order.
// Depends on b32e_pkg and the encoder RTL.
module base32_stream_encoder_top_test;
  import b32e_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RandomBytes = 88;
  localparam logic [8*32-1:0] Base32Alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;

  in_word_t  pending_bytes[$];
  out_word_t expected_chars[$];

  // Encoder state as the predictor sees it.
  logic [2:0] group_pos = 3'd0;
  logic [3:0] carry_bits = 4'd0;

  int   error_count = 0;
  int   bytes_taken = 0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  bit   steady_send = 1'b0;
  bit   steady_recv = 1'b0;
  bit   long_hold_done = 1'b0;
  logic next_push;

  wire in_taken  = push && !full;
  wire out_taken = pop && !empty;

  base32_stream_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [6:0] symbol_ascii(input logic [4:0] v);
    logic [7:0] c;
    c = Base32Alphabet[8 * (31 - int'(v)) +: 8];
    return c[6:0];
  endfunction

  // Expected characters for one byte, appended to expected_chars.
  task automatic encode_byte(input in_word_t w);
    logic [6:0] chars[8];
    logic [7:0] b;
    logic [4:0] flush_sym;
    logic [3:0] carry;
    int         n;
    int         pads;
    out_word_t  ow;
    b = w.data_byte;
    n = 0;
    pads = 0;
    flush_sym = '0;
    carry = '0;
    case (group_pos)
      3'd1: begin
        chars[0] = symbol_ascii({carry_bits[2:0], b[7:6]});
        chars[1] = symbol_ascii(b[5:1]);
        n = 2;
        carry = {3'b000, b[0]};
        flush_sym = {b[0], 4'b0000};
        pads = 4;
      end
      3'd2: begin
        chars[0] = symbol_ascii({carry_bits[0], b[7:4]});
        n = 1;
        carry = b[3:0];
        flush_sym = {b[3:0], 1'b0};
        pads = 3;
      end
      3'd3: begin
        chars[0] = symbol_ascii({carry_bits[3:0], b[7]});
        chars[1] = symbol_ascii(b[6:2]);
        n = 2;
        carry = {2'b00, b[1:0]};
        flush_sym = {b[1:0], 3'b000};
        pads = 1;
      end
      LastPos: begin
        chars[0] = symbol_ascii({carry_bits[1:0], b[7:5]});
        chars[1] = symbol_ascii(b[4:0]);
        n = 2;
      end
      default: begin
        // Position zero; an out-of-range position behaves the same way.
        chars[0] = symbol_ascii(b[7:3]);
        n = 1;
        carry = {1'b0, b[2:0]};
        flush_sym = {b[2:0], 2'b00};
        pads = 6;
      end
    endcase
    if (w.final_byte) begin
      // A final byte at the last position closes a full group: no flush, no padding.
      if (group_pos != LastPos) begin
        chars[n] = symbol_ascii(flush_sym);
        n = n + 1;
        for (int i = 0; i < pads; i++) begin
          chars[n] = PadChar;
          n = n + 1;
        end
      end
      group_pos = 3'd0;
      carry_bits = 4'd0;
    end else begin
      group_pos = (group_pos >= LastPos) ? 3'd0 : group_pos + 3'd1;
      carry_bits = carry;
    end
    for (int i = 0; i < n; i++) begin
      ow.char_code = chars[i];
      ow.last_of_run = (i == n - 1);
      expected_chars = {expected_chars, ow};
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    in_word_t w;
    w.data_byte = b;
    w.final_byte = fin;
    pending_bytes = {pending_bytes, w};
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(6, 30);
    end
  endfunction

  // Sender: holds its word until it is taken, then waits out a random gap.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        encode_byte(in_word);
        void'(pending_bytes.pop_front());
        bytes_taken++;
        send_gap = steady_send ? 0 : draw_gap();
        if ($urandom_range(0, 15) == 0) begin
          steady_send = !steady_send;
        end
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0) begin
          next_push = 1'b1;
          in_word <= pending_bytes[0];
        end
      end
      push <= next_push;
    end
  end

  // Receiver: checks each taken word against the oldest expected character.
  always @(posedge clk_i) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, got char %h last %b",
                   $time, out_word.char_code, out_word.last_of_run);
          error_count++;
        end else begin
          if (out_word.char_code !== expected_chars[0].char_code) begin
            $display("%0t: char_code mismatch, expected %h, got %h",
                     $time, expected_chars[0].char_code, out_word.char_code);
            error_count++;
          end
          if (out_word.last_of_run !== expected_chars[0].last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %b, got %b",
                     $time, expected_chars[0].last_of_run, out_word.last_of_run);
            error_count++;
          end
          void'(expected_chars.pop_front());
        end
      end
      // One long hold-off mid-run so that the job queue fills and full rises.
      if (!long_hold_done && bytes_taken >= 40) begin
        hold_left = 80;
        long_hold_done = 1'b1;
      end
      if ($urandom_range(0, 31) == 0) begin
        steady_recv = !steady_recv;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (steady_recv) begin
        pop <= 1'b1;
      end else begin
        stall_left = draw_gap();
        pop <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || in_taken || out_taken) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int total;
    int len;
    // Standard vectors end a message at every group position.
    queue_text("f");
    queue_text("fo");
    queue_text("foo");
    queue_text("foob");
    queue_text("fooba");
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b1);
    total = 0;
    while (total < RandomBytes) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        queue_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      total += len;
    end

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
